// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the polygon area and centroid RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pac assertion failed");
`define PAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pac assertion failed");
`else
`define PAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Shared constants, codes and types of the polygon area and centroid block.
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int MAX_CORNERS_DEF = 8;

    localparam int XY_W    = 16;
    localparam int AREA_W  = 24;
    localparam int FRAC_W  = 16;
    localparam int COUNT_W = 4;
    localparam int ERR_W   = 2;
    localparam int CS_W    = 16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam int QUO_W = FRAC_W + 1;
    localparam int QCNT_W = $clog2(QUO_W);

    localparam int CENT_NEG_LIM = 2 ** (XY_W - 1);
    localparam int CENT_POS_LIM = 2 ** (XY_W - 1) - 1;

    localparam logic [CS_W-1:0] CELL_SIZE_RST = CS_W'(4096);
    localparam logic [APB_AW-3:0] REG_IDX_CELL_SIZE = '0;

    localparam logic [ERR_W-1:0] ERR_NONE      = ERR_W'(0);
    localparam logic [ERR_W-1:0] ERR_ZERO_AREA = ERR_W'(1);
    localparam logic [ERR_W-1:0] ERR_TOO_MANY  = ERR_W'(2);

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

// File: src/pac_if.sv
// ----------------------------------------------------------------------------
// pac_if
// Valid/ready channels for polygon vertices and polygon results.
// ----------------------------------------------------------------------------
interface pac_vtx_if;
    import pac_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [XY_W-1:0] vertex_x;
    logic signed [XY_W-1:0] vertex_y;
    logic                   last_vertex;

    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pac_res_if;
    import pac_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [AREA_W-1:0]      area;
    logic signed [XY_W-1:0] centroid_x;
    logic signed [XY_W-1:0] centroid_y;
    logic [FRAC_W-1:0]      area_fraction;
    logic [COUNT_W-1:0]     corner_count;
    logic [ERR_W-1:0]       error_code;

    modport source (output valid, area, centroid_x, centroid_y, area_fraction,
                    corner_count, error_code, input ready);
    modport sink   (input valid, area, centroid_x, centroid_y, area_fraction,
                    corner_count, error_code, output ready);
endinterface

// File: src/polygon_area_centroid_top.sv
// ----------------------------------------------------------------------------
// polygon_area_centroid_top
// Shoelace area and centroid of a closed polygon streamed one vertex at a
// time, with a cell size register for the area fraction.
//
// Channel    Direction  Transaction
// i_vertex   in         one vertex (x, y, last flag)
// o_result   out        one polygon result (area, centroid, fraction, count,
//                       error code)
// APB        in         write or read of the cell size register
//
// A vertex is accepted and then takes four front end steps: the edge cross
// term in two and the two moments on one shared moment multiplier.
// The final vertex adds the closing edge and a queue push.
// The back end runs up to three 17-bit restoring divisions per polygon; a
// two-entry queue lets the front run ahead of it.
// Reset clears all control state at once; there is no clearing pass.
// The result register holds a transaction until it is taken while the back
// end already works on the next polygon.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polygon_area_centroid_top #(
    parameter int MAX_CORNERS = pac_pkg::MAX_CORNERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pac_vtx_if.sink                     i_vertex,
    pac_res_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pac_pkg::APB_AW-1:0]  paddr,
    input  logic [pac_pkg::APB_DW-1:0]  pwdata,
    output logic [pac_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import pac_pkg::*;

    localparam int K   = $clog2(MAX_CORNERS);
    localparam int A2W = 34 + K;
    localparam int MW  = 49 + K;
    localparam int SW  = $clog2(MAX_CORNERS + 2);
    localparam int WW  = (MW + 1 > A2W + 18) ? MW + 1 : A2W + 18;
    localparam int QW  = A2W + 2 * MW + SW;
    localparam int COUNT_SAT = (MAX_CORNERS > 2 ** COUNT_W - 1) ? 2 ** COUNT_W - 1
                                                                : MAX_CORNERS;

    logic [CS_W-1:0] r_cell_size;
    logic w_cfg_sel;

    logic w_push, w_q_full, w_pop, w_q_empty;
    logic signed [A2W-1:0] w_f_a2, w_b_a2;
    logic signed [MW-1:0] w_f_mx, w_f_my, w_b_mx, w_b_my;
    logic [SW-1:0] w_f_seen, w_b_seen;
    logic [QW-1:0] w_q_wdata, w_q_rdata;

    logic w_div_start;
    logic [WW-1:0] w_div_num, w_div_den;
    t_div_rsp w_div_rsp;

    logic w_last_accept;
    logic w_zero_err, w_zero_clean;
    logic w_many_err, w_many_clean;

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[APB_AW-1:2] == REG_IDX_CELL_SIZE);
    assign prdata    = w_cfg_sel ? APB_DW'(r_cell_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= CELL_SIZE_RST;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_cell_size <= pwdata[CS_W-1:0];
        end
    end

    pac_front #(
        .MAX_CORNERS (MAX_CORNERS),
        .A2W         (A2W),
        .MW          (MW),
        .SW          (SW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vertex (i_vertex),
        .o_push   (w_push),
        .i_full   (w_q_full),
        .o_a2     (w_f_a2),
        .o_mx     (w_f_mx),
        .o_my     (w_f_my),
        .o_seen   (w_f_seen)
    );

    assign w_q_wdata = {w_f_a2, w_f_mx, w_f_my, w_f_seen};
    assign {w_b_a2, w_b_mx, w_b_my, w_b_seen} = w_q_rdata;

    pac_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_rdata (w_q_rdata),
        .o_empty (w_q_empty)
    );

    pac_div #(
        .WW (WW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_rsp   (w_div_rsp)
    );

    pac_back #(
        .MAX_CORNERS (MAX_CORNERS),
        .A2W         (A2W),
        .MW          (MW),
        .SW          (SW),
        .WW          (WW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!w_q_empty),
        .o_pop       (w_pop),
        .i_a2        (w_b_a2),
        .i_mx        (w_b_mx),
        .i_my        (w_b_my),
        .i_seen      (w_b_seen),
        .i_cell_size (r_cell_size),
        .o_div_start (w_div_start),
        .o_div_num   (w_div_num),
        .o_div_den   (w_div_den),
        .i_div_rsp   (w_div_rsp),
        .o_result    (o_result)
    );

    assign w_last_accept = i_vertex.valid && i_vertex.ready && i_vertex.last_vertex;
    assign w_zero_err    = o_result.valid && (o_result.error_code == ERR_ZERO_AREA);
    assign w_zero_clean  = (o_result.area == '0) && (o_result.area_fraction == '0)
                           && (o_result.centroid_x == '0) && (o_result.centroid_y == '0);
    assign w_many_err    = o_result.valid && (o_result.error_code == ERR_TOO_MANY);
    assign w_many_clean  = (o_result.centroid_x == '0) && (o_result.centroid_y == '0)
                           && (o_result.corner_count == COUNT_W'(COUNT_SAT));

    `PAC_ASSERT_IMP(a_queue_no_overflow, i_clk, i_rst_n, w_push, !w_q_full)
    `PAC_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, w_last_accept, !i_vertex.ready)
    `PAC_ASSERT_IMP(a_zero_area_result, i_clk, i_rst_n, w_zero_err, w_zero_clean)
    `PAC_ASSERT_IMP(a_too_many_result, i_clk, i_rst_n, w_many_err, w_many_clean)
endmodule

// File: src/pac_queue.sv
// ----------------------------------------------------------------------------
// pac_queue
// Small register queue that carries finished polygon sums to the back end.
// ----------------------------------------------------------------------------
module pac_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push_ok;
    logic          w_pop_ok;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: src/pac_front.sv
// ----------------------------------------------------------------------------
// pac_front
// Vertex intake: keeps the first and previous vertex and accumulates the
// shoelace cross terms and centroid moments, one edge at a time.
// ----------------------------------------------------------------------------
module pac_front #(
    parameter int MAX_CORNERS = 8,
    parameter int A2W         = 37,
    parameter int MW          = 52,
    parameter int SW          = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pac_vtx_if.sink               i_vertex,
    output logic                  o_push,
    input  logic                  i_full,
    output logic signed [A2W-1:0] o_a2,
    output logic signed [MW-1:0]  o_mx,
    output logic signed [MW-1:0]  o_my,
    output logic [SW-1:0]         o_seen
);
    import pac_pkg::*;

    localparam int PW   = 2 * XY_W;
    localparam int CW   = PW + 1;
    localparam int SUMW = XY_W + 1;
    localparam int EW   = SUMW + CW;

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_P1    = 7'b0000010,
        F_C     = 7'b0000100,
        F_MX    = 7'b0001000,
        F_MY    = 7'b0010000,
        F_CLOSE = 7'b0100000,
        F_PUSH  = 7'b1000000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [SW-1:0] r_seen, n_seen;
    logic r_last, n_last;
    logic r_closing, n_closing;
    logic signed [A2W-1:0] r_a2, n_a2;
    logic signed [MW-1:0] r_mx, n_mx, r_my, n_my;
    logic signed [XY_W-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [XY_W-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [XY_W-1:0] r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic signed [PW-1:0] r_p, n_p;
    logic signed [CW-1:0] r_c, n_c;
    logic signed [SUMW-1:0] w_msum;
    logic signed [EW-1:0] w_mom;

    assign i_vertex.ready = (r_state == F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_a2   = r_a2;
    assign o_mx   = r_mx;
    assign o_my   = r_my;
    assign o_seen = r_seen;

    assign w_msum = (r_state == F_MY) ? SUMW'(r_y0) + SUMW'(r_y1)
                                      : SUMW'(r_x0) + SUMW'(r_x1);
    assign w_mom  = EW'(w_msum) * EW'(r_c);

    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_last    = r_last;
        n_closing = r_closing;
        n_a2      = r_a2;
        n_mx      = r_mx;
        n_my      = r_my;
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_x0      = r_x0;
        n_y0      = r_y0;
        n_x1      = r_x1;
        n_y1      = r_y1;
        n_p       = r_p;
        n_c       = r_c;
        case (r_state)
            F_IDLE: begin
                if (i_vertex.valid) begin
                    if (r_seen < SW'(MAX_CORNERS)) begin
                        if (r_seen == '0) begin
                            n_first_x = i_vertex.vertex_x;
                            n_first_y = i_vertex.vertex_y;
                        end
                        n_prev_x = i_vertex.vertex_x;
                        n_prev_y = i_vertex.vertex_y;
                    end
                    if (r_seen <= SW'(MAX_CORNERS)) begin
                        n_seen = r_seen + 1'b1;
                    end
                    n_last = i_vertex.last_vertex;
                    if (r_seen != '0 && r_seen < SW'(MAX_CORNERS)) begin
                        n_x0    = r_prev_x;
                        n_y0    = r_prev_y;
                        n_x1    = i_vertex.vertex_x;
                        n_y1    = i_vertex.vertex_y;
                        n_state = F_P1;
                    end else if (i_vertex.last_vertex) begin
                        n_state = F_CLOSE;
                    end
                end
            end
            F_P1: begin
                n_p     = PW'(r_x0) * PW'(r_y1);
                n_state = F_C;
            end
            F_C: begin
                n_c     = CW'(r_p) - CW'(r_x1) * CW'(r_y0);
                n_state = F_MX;
            end
            F_MX: begin
                n_a2    = r_a2 + A2W'(r_c);
                n_mx    = r_mx + MW'(w_mom);
                n_state = F_MY;
            end
            F_MY: begin
                n_my = r_my + MW'(w_mom);
                if (r_closing) begin
                    n_state = F_PUSH;
                end else if (r_last) begin
                    n_state = F_CLOSE;
                end else begin
                    n_state = F_IDLE;
                end
            end
            F_CLOSE: begin
                n_x0      = r_prev_x;
                n_y0      = r_prev_y;
                n_x1      = r_first_x;
                n_y1      = r_first_y;
                n_closing = 1'b1;
                n_state   = F_P1;
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_seen    = '0;
                    n_last    = 1'b0;
                    n_closing = 1'b0;
                    n_a2      = '0;
                    n_mx      = '0;
                    n_my      = '0;
                    n_state   = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_seen    <= '0;
            r_last    <= 1'b0;
            r_closing <= 1'b0;
            r_a2      <= '0;
            r_mx      <= '0;
            r_my      <= '0;
        end else begin
            r_state   <= n_state;
            r_seen    <= n_seen;
            r_last    <= n_last;
            r_closing <= n_closing;
            r_a2      <= n_a2;
            r_mx      <= n_mx;
            r_my      <= n_my;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_x <= n_first_x;
        r_first_y <= n_first_y;
        r_prev_x  <= n_prev_x;
        r_prev_y  <= n_prev_y;
        r_x0      <= n_x0;
        r_y0      <= n_y0;
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_p       <= n_p;
        r_c       <= n_c;
    end
endmodule

// File: src/pac_div.sv
// ----------------------------------------------------------------------------
// pac_div
// Restoring divider with a saturation check, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pac_div #(
    parameter int WW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WW-1:0]         i_num,
    input  logic [WW-1:0]         i_den,
    output pac_pkg::t_div_rsp     o_rsp
);
    import pac_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_STEP  = 3'b100
    } t_dstate;

    t_dstate r_state, n_state;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic r_done, n_done;
    logic r_ovf, n_ovf;
    logic [WW-1:0] r_rem, n_rem, r_den, n_den, r_div, n_div;
    logic [QUO_W-1:0] r_q, n_q;

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quo  = r_q;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        n_rem   = r_rem;
        n_den   = r_den;
        n_div   = r_div;
        n_q     = r_q;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_rem   = i_num;
                    n_den   = i_den;
                    n_state = D_CHECK;
                end
            end
            D_CHECK: begin
                n_ovf = (r_rem >> QUO_W) >= r_den;
                n_div = r_den << (QUO_W - 1);
                n_q   = '0;
                n_cnt = '0;
                if (n_ovf) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end else begin
                    n_state = D_STEP;
                end
            end
            D_STEP: begin
                if (r_rem >= r_div) begin
                    n_rem = r_rem - r_div;
                    n_q   = {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[QUO_W-2:0], 1'b0};
                end
                n_div = r_div >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(QUO_W - 1)) begin
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf <= n_ovf;
        r_rem <= n_rem;
        r_den <= n_den;
        r_div <= n_div;
        r_q   <= n_q;
    end
endmodule

// File: src/pac_back.sv
// ----------------------------------------------------------------------------
// pac_back
// Result stage: takes finished polygon sums, runs the needed divisions (area
// fraction, centroids if no error) on the shared divider, holds the result.
// ----------------------------------------------------------------------------
module pac_back #(
    parameter int MAX_CORNERS = 8,
    parameter int A2W         = 37,
    parameter int MW          = 52,
    parameter int SW          = 4,
    parameter int WW          = 55
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_pop,
    input  logic signed [A2W-1:0]        i_a2,
    input  logic signed [MW-1:0]         i_mx,
    input  logic signed [MW-1:0]         i_my,
    input  logic [SW-1:0]                i_seen,
    input  logic [pac_pkg::CS_W-1:0]     i_cell_size,
    output logic                         o_div_start,
    output logic [WW-1:0]                o_div_num,
    output logic [WW-1:0]                o_div_den,
    input  pac_pkg::t_div_rsp            i_div_rsp,
    pac_res_if.source                    o_result
);
    import pac_pkg::*;

    localparam int ASW     = A2W + 1;
    localparam int CNT_TOP = 2 ** COUNT_W - 1;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_START = 4'b0010,
        B_WAIT  = 4'b0100,
        B_EMIT  = 4'b1000
    } t_bstate;

    typedef enum logic [2:0] {
        J_FRAC = 3'b001,
        J_CX   = 3'b010,
        J_CY   = 3'b100
    } t_job;

    t_bstate r_state, n_state;
    t_job r_job, n_job;
    logic r_out_valid, n_out_valid;
    logic [A2W-1:0] r_a2m, n_a2m;
    logic r_a2_neg, n_a2_neg;
    logic [MW-1:0] r_mxm, n_mxm, r_mym, n_mym;
    logic r_mx_neg, n_mx_neg, r_my_neg, n_my_neg;
    logic [2*CS_W-1:0] r_den_f, n_den_f;
    logic [ERR_W-1:0] r_err, n_err;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [XY_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [AREA_W-1:0] r_out_area, n_out_area;
    logic [XY_W-1:0] r_out_cx, n_out_cx, r_out_cy, n_out_cy;
    logic [FRAC_W-1:0] r_out_frac, n_out_frac;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic [ERR_W-1:0] r_out_err, n_out_err;

    logic [SW-1:0] w_cnt_clip;
    logic [MW-1:0] w_mm;
    logic w_neg;
    logic [WW-1:0] w_a3;
    logic [ASW-1:0] w_area_sum;
    logic [ASW-1:0] w_area_sh;
    logic [XY_W-1:0] w_cent;

    function automatic logic [XY_W-1:0] sat_centroid(input logic neg, input logic ovf,
                                                     input logic [QUO_W-1:0] q);
        logic [QUO_W-1:0] m;
        if (neg) begin
            m = (ovf || q > QUO_W'(CENT_NEG_LIM)) ? QUO_W'(CENT_NEG_LIM) : q;
            return XY_W'(~m + 1'b1);
        end
        m = (ovf || q > QUO_W'(CENT_POS_LIM)) ? QUO_W'(CENT_POS_LIM) : q;
        return XY_W'(m);
    endfunction

    assign o_result.valid         = r_out_valid;
    assign o_result.area          = r_out_area;
    assign o_result.centroid_x    = r_out_cx;
    assign o_result.centroid_y    = r_out_cy;
    assign o_result.area_fraction = r_out_frac;
    assign o_result.corner_count  = r_out_count;
    assign o_result.error_code    = r_out_err;

    assign o_pop = (r_state == B_IDLE) && i_q_valid;

    assign w_cnt_clip = (i_seen > SW'(MAX_CORNERS)) ? SW'(MAX_CORNERS) : i_seen;
    assign w_mm  = (r_job == J_CY) ? r_mym : r_mxm;
    assign w_neg = ((r_job == J_CY) ? r_my_neg : r_mx_neg) ^ r_a2_neg;
    assign w_a3  = WW'(r_a2m) + (WW'(r_a2m) << 1);
    assign w_area_sum = ASW'(r_a2m) + ASW'(4096);
    assign w_area_sh  = w_area_sum >> 13;
    assign w_cent = sat_centroid(w_neg, i_div_rsp.ovf, i_div_rsp.quo);

    always_comb begin
        if (r_job == J_FRAC) begin
            o_div_num = (WW'(r_a2m) << 14) + WW'(r_den_f);
            o_div_den = WW'(r_den_f) << 1;
        end else begin
            o_div_num = (WW'(w_mm) << 1) + w_a3;
            o_div_den = w_a3 << 1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_out_valid = r_out_valid && !o_result.ready;
        n_a2m       = r_a2m;
        n_a2_neg    = r_a2_neg;
        n_mxm       = r_mxm;
        n_mym       = r_mym;
        n_mx_neg    = r_mx_neg;
        n_my_neg    = r_my_neg;
        n_den_f     = r_den_f;
        n_err       = r_err;
        n_count     = r_count;
        n_frac      = r_frac;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_out_area  = r_out_area;
        n_out_cx    = r_out_cx;
        n_out_cy    = r_out_cy;
        n_out_frac  = r_out_frac;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;
        o_div_start = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    n_a2_neg = i_a2[A2W-1];
                    n_a2m    = i_a2[A2W-1] ? A2W'(-i_a2) : A2W'(i_a2);
                    n_mx_neg = i_mx[MW-1];
                    n_mxm    = i_mx[MW-1] ? MW'(-i_mx) : MW'(i_mx);
                    n_my_neg = i_my[MW-1];
                    n_mym    = i_my[MW-1] ? MW'(-i_my) : MW'(i_my);
                    n_den_f  = (2*CS_W)'(i_cell_size) * (2*CS_W)'(i_cell_size);
                    if (i_seen > SW'(MAX_CORNERS)) begin
                        n_err = ERR_TOO_MANY;
                    end else if (i_a2 == '0) begin
                        n_err = ERR_ZERO_AREA;
                    end else begin
                        n_err = ERR_NONE;
                    end
                    if (32'(w_cnt_clip) > 32'(CNT_TOP)) begin
                        n_count = COUNT_W'(CNT_TOP);
                    end else begin
                        n_count = COUNT_W'(w_cnt_clip);
                    end
                    n_frac  = '0;
                    n_cx    = '0;
                    n_cy    = '0;
                    n_job   = J_FRAC;
                    n_state = B_START;
                end
            end
            B_START: begin
                case (r_job)
                    J_FRAC: begin
                        if (r_a2m == '0) begin
                            n_job = J_CX;
                        end else if (i_cell_size == '0) begin
                            n_frac = '1;
                            n_job  = J_CX;
                        end else begin
                            o_div_start = 1'b1;
                            n_state     = B_WAIT;
                        end
                    end
                    J_CX: begin
                        if (r_err != ERR_NONE) begin
                            n_job = J_CY;
                        end else begin
                            o_div_start = 1'b1;
                            n_state     = B_WAIT;
                        end
                    end
                    J_CY: begin
                        if (r_err != ERR_NONE) begin
                            n_state = B_EMIT;
                        end else begin
                            o_div_start = 1'b1;
                            n_state     = B_WAIT;
                        end
                    end
                    default: begin
                        n_job = J_FRAC;
                    end
                endcase
            end
            B_WAIT: begin
                if (i_div_rsp.done) begin
                    case (r_job)
                        J_FRAC: begin
                            n_frac  = (i_div_rsp.ovf || i_div_rsp.quo[QUO_W-1]) ? '1
                                    : i_div_rsp.quo[FRAC_W-1:0];
                            n_job   = J_CX;
                            n_state = B_START;
                        end
                        J_CX: begin
                            n_cx    = w_cent;
                            n_job   = J_CY;
                            n_state = B_START;
                        end
                        J_CY: begin
                            n_cy    = w_cent;
                            n_state = B_EMIT;
                        end
                        default: begin
                            n_state = B_START;
                        end
                    endcase
                end
            end
            B_EMIT: begin
                if (!r_out_valid || o_result.ready) begin
                    if (w_area_sh > ASW'({AREA_W{1'b1}})) begin
                        n_out_area = '1;
                    end else begin
                        n_out_area = AREA_W'(w_area_sh);
                    end
                    n_out_cx    = r_cx;
                    n_out_cy    = r_cy;
                    n_out_frac  = r_frac;
                    n_out_count = r_count;
                    n_out_err   = r_err;
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_job       <= J_FRAC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a2m       <= n_a2m;
        r_a2_neg    <= n_a2_neg;
        r_mxm       <= n_mxm;
        r_mym       <= n_mym;
        r_mx_neg    <= n_mx_neg;
        r_my_neg    <= n_my_neg;
        r_den_f     <= n_den_f;
        r_err       <= n_err;
        r_count     <= n_count;
        r_frac      <= n_frac;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_out_area  <= n_out_area;
        r_out_cx    <= n_out_cx;
        r_out_cy    <= n_out_cy;
        r_out_frac  <= n_out_frac;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end
endmodule
